### rtl/tdpt_pkg.sv
// shared constants for the trial-division prime test
// no dependencies
package tdpt_pkg;

  localparam int unsigned NUM_WIDTH_DEF = 32;
  localparam int unsigned TWO           = 2;
  localparam int unsigned THREE         = 3;

endpackage

### rtl/trial_division_prime_test.sv
// top level of the trial-division prime test: sequencer around one shared divider
// depends on tdpt_pkg and tdpt_div
//
//  port group         direction  handshake
//  start / candidate  in         taken when start is high and busy is low
//  done / is_prime    out        one-cycle strobe, no back-pressure
//
// candidates up to 2 and even candidates give their result the cycle after the item is taken
// each odd trial divisor takes one full pass through the shared bit-serial divider
// worst case about sqrt(candidate)/2 divisors
// synchronous reset returns to idle with no result pending
// busy stays high until the result strobe; the receiver cannot stall
module trial_division_prime_test
  import tdpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] candidate,
  output logic                 busy,
  output logic                 done,
  output logic                 is_prime
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                 state;
  logic                 div_go;
  logic [NUM_WIDTH-1:0] num;
  logic [NUM_WIDTH-1:0] dvs;

  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;

  tdpt_div #(.NUM_WIDTH(NUM_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (num),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            num <= candidate;
            dvs <= NUM_WIDTH'(THREE);
            if (candidate <= NUM_WIDTH'(TWO)) begin
              done     <= 1'b1;
              is_prime <= (candidate == NUM_WIDTH'(TWO));
            end else if (!candidate[0]) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
            end else begin
              div_go <= 1'b1;
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (div_done) begin
            // loop ends once the divisor passes the quotient or leaves no remainder
            if (dvs > div_quo) begin
              done     <= 1'b1;
              is_prime <= 1'b1;
              state    <= S_IDLE;
            end else if (div_rem == '0) begin
              done     <= 1'b1;
              is_prime <= 1'b0;
              state    <= S_IDLE;
            end else begin
              dvs    <= dvs + NUM_WIDTH'(TWO);
              div_go <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/tdpt_div.sv
// restoring divider, one quotient bit per cycle
// standalone, used by trial_division_prime_test
module tdpt_div #(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [NUM_WIDTH-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(NUM_WIDTH);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [NUM_WIDTH-1:0] rem;
  logic [NUM_WIDTH-1:0] quo;
  logic [NUM_WIDTH-1:0] dvs;

  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   diff;
  logic                 fits;
  logic [NUM_WIDTH-1:0] rem_next;
  logic [NUM_WIDTH-1:0] quo_next;

  // partial remainder stays below the divisor, so the shifted value fits in one extra bit
  always_comb begin
    shifted  = {rem, quo[NUM_WIDTH-1]};
    diff     = shifted - {1'b0, dvs};
    fits     = !diff[NUM_WIDTH];
    rem_next = fits ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
    quo_next = {quo[NUM_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (go && !active) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= '0;
      rem    <= '0;
      quo    <= dividend;
      dvs    <= divisor;
    end else if (active) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(NUM_WIDTH - 1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/tdpt_checker.sv
// port-level checks for trial_division_prime_test, bound to the top level
// depends on tdpt_pkg
module tdpt_checker
  import tdpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic [NUM_WIDTH-1:0] candidate,
  input logic                 busy,
  input logic                 done,
  input logic                 is_prime
);

  // a taken item either starts work or finishes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("item taken but neither busy nor done");

  a_done_frees: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  // no result without an item in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !done)
    else $error("result with no item in flight");

  // even items finish next cycle, prime only when two
  a_even_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !candidate[0]) |=>
      (done && (is_prime == ($past(candidate) == NUM_WIDTH'(TWO)))))
    else $error("wrong fast result for an even item");

endmodule

bind trial_division_prime_test tdpt_checker #(.NUM_WIDTH(NUM_WIDTH)) u_tdpt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .candidate(candidate),
  .busy     (busy),
  .done     (done),
  .is_prime (is_prime)
);

### tb/tb_top.sv
// self-checking testbench for trial_division_prime_test
// drives candidates through the start/busy handshake and checks each done strobe
// depends on tdpt_pkg and the rtl of trial_division_prime_test
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpt_pkg::*;

  localparam int unsigned W = NUM_WIDTH_DEF;
  localparam int unsigned PERIOD = 20;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam longint unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [W-1:0] cand;
    bit           has_typed;
    bit           typed_prime;
  } stim_row_t;

  typedef struct {
    logic [W-1:0] cand;
    bit           prime;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         start;
  logic [W-1:0] candidate;
  logic         busy;
  logic         done;
  logic         is_prime;

  verdict_t        pending_verdicts[$];
  int unsigned     items_sent;
  int unsigned     verdicts_checked;
  int unsigned     primes_seen;
  int unsigned     mismatches;
  longint unsigned cycle_count;

  // typed verdicts only where they follow straight from the rules
  stim_row_t directed_rows [21] = '{
    '{32'd0,          1'b1, 1'b0},
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b1, 1'b1},
    '{32'd4,          1'b1, 1'b0},
    '{32'hFFFF_FFFE,  1'b1, 1'b0},
    '{32'h8000_0000,  1'b1, 1'b0},
    '{32'hAAAA_AAAA,  1'b1, 1'b0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0},
    '{32'h5555_5555,  1'b0, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd9,          1'b0, 1'b0},
    '{32'd15,         1'b0, 1'b0},
    '{32'd25,         1'b0, 1'b0},
    '{32'd49,         1'b0, 1'b0},
    '{32'd97,         1'b0, 1'b0},
    '{32'd121,        1'b0, 1'b0},
    '{32'd65535,      1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'd16752649,   1'b0, 1'b0}  // square of the prime 4093
  };

  trial_division_prime_test u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .candidate (candidate),
    .busy      (busy),
    .done      (done),
    .is_prime  (is_prime)
  );

  always #(PERIOD / 2) clk = ~clk;

  function automatic bit prime_by_division(input logic [W-1:0] n);
    logic [63:0] num;
    logic [63:0] div;
    num = 64'(n);
    if (num <= TWO) return num == TWO;
    if (!num[0]) return 1'b0;
    // div <= num / div is the same as div * div <= num without overflow
    for (div = THREE; div <= num / div; div += 2) begin
      if (num % div == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // returns at the edge where the item was taken, start still high
  task automatic send_candidate(input logic [W-1:0] cand, input bit has_typed,
                                input bit typed_prime, input int unsigned idle_pct);
    verdict_t v;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    candidate <= cand;
    do @(posedge clk); while (!(start && !busy));
    v.cand  = cand;
    v.prime = has_typed ? typed_prime : prime_by_division(cand);
    pending_verdicts = {pending_verdicts, v};
    items_sent++;
  endtask

  // sender holds off until every verdict in flight has come back
  task automatic wait_for_verdicts();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned idle_pct);
    logic [W-1:0] cand;
    int unsigned  pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      // large odd primes run the divider for every odd divisor up to their square root, so big values are kept cheap
      if (pick < 55) begin
        cand = $urandom_range(4095);
      end else if (pick < 80) begin
        cand = $urandom_range(32'h000F_FFFF);
      end else if (pick < 90) begin
        cand    = $urandom();
        cand[0] = 1'b0;
      end else begin
        cand = 3 * $urandom_range(32'h5555_5555);
      end
      send_candidate(cand, 1'b0, 1'b0, idle_pct);
    end
    wait_for_verdicts();
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result is_prime=%0b", is_prime));
      end else begin
        v = pending_verdicts.pop_front();
        verdicts_checked++;
        if (is_prime !== v.prime) begin
          report_mismatch($sformatf("candidate %0d expected is_prime=%0b got %0b",
                                    v.cand, v.prime, is_prime));
        end else if (is_prime) begin
          primes_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, pending_verdicts.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    candidate = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_candidate(directed_rows[i].cand, directed_rows[i].has_typed,
                     directed_rows[i].typed_prime, 0);
    end
    wait_for_verdicts();

    random_phase(25, 0);
    random_phase(20, 71);
    random_phase(20, 31);
    random_phase(15, 0);

    repeat (TAIL_CYCLES) @(posedge clk);
    foreach (pending_verdicts[i]) begin
      report_mismatch($sformatf("no result for candidate %0d", pending_verdicts[i].cand));
    end

    $display("tested %0d candidates (extremes, small squares, random) in %0d cycles",
             items_sent, cycle_count);
    $display("%0d verdicts checked, %0d primes, %0d mismatches",
             verdicts_checked, primes_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
